/* rtl/core/b64_pkg.sv */
`default_nettype none

package b64_pkg;

  localparam int unsigned JobDepth = 4;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [6:0] PadCode = 7'd64;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic        mode;
    logic [23:0] group;
    logic [2:0]  nres;
    logic [2:0]  nchar;
    logic        last;
  } job_t;

  function automatic logic [7:0] sextet_to_char(logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      return 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  function automatic logic [6:0] char_to_sextet(logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      t = 8'd62;
    end else if (c == 8'h2F) begin
      t = 8'd63;
    end else if (c == PadChar) begin
      t = {1'b0, PadCode};
    end
    return t[6:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/base64_codec_stream.sv */
`default_nettype none

// Base64 stream codec, encode or decode picked by a one-bit direction register.
// Input channel: push / full, one byte or character per transfer with a
// last-of-message flag. Output channel: empty / pop, the oldest result sits on
// out_item_o while empty is low and leaves on a transfer.
// Configuration: cfg_we_i writes cfg_wdata_i into the direction register and
// drops any partial group; write it only while the block is idle.
// A front stage collects groups (three bytes or four characters) and pushes a
// job into a four-entry job queue; a back stage expands each job into its
// results, one per cycle while the receiver pops, into a single output
// register. The first result of a group passes through the job queue and
// then the output register. Throughput: one input per cycle into the front
// while full is low, one result per cycle out of the back while the receiver
// pops; encoding is bounded by the output at four results per three inputs.
// When the receiver stalls, the output register holds, the job queue fills and
// full rises; nothing is dropped. Reset clears the direction (encode), the
// partial group and the job queue, and marks the output register empty.

module base64_codec_stream (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               push,
  output logic                    full,
  input  wire b64_pkg::in_item_t  in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output b64_pkg::out_item_t      out_item_o
);

  b64_pkg::job_t front_job;
  b64_pkg::job_t head_job;
  logic          job_push;
  logic          job_pop;
  logic          q_full;
  logic          q_empty;
  logic          accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .job_o       (front_job),
    .job_push_o  (job_push)
  );

  b64_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (job_pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  b64_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_job_i    (head_job),
    .q_pop_o    (job_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

/* rtl/core/b64_front.sv */
`default_nettype none

module b64_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic              accept_i,
  input  wire b64_pkg::in_item_t in_item_i,
  output b64_pkg::job_t          job_o,
  output logic                   job_push_o
);

  logic        dir_q;
  logic [23:0] hold_q, hold_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  pad_q, pad_d;

  logic [2:0]  k;
  logic        done;
  logic [6:0]  sx;
  logic        is_pad;
  logic [2:0]  pads;
  b64_pkg::job_t job;

  always_comb begin
    k      = {1'b0, cnt_q} + 3'd1;
    sx     = b64_pkg::char_to_sextet(in_item_i.in_byte);
    is_pad = (sx == b64_pkg::PadCode);
    pad_d  = pad_q;
    pads   = 3'd0;
    job    = '0;
    job.mode = dir_q;
    job.last = in_item_i.in_last;
    if (!dir_q) begin
      hold_d = {hold_q[15:0], in_item_i.in_byte};
      done   = in_item_i.in_last || (k == 3'd3);
      unique case (k)
        3'd1:    job.group = {hold_d[7:0], 16'h0000};
        3'd2:    job.group = {hold_d[15:0], 8'h00};
        default: job.group = hold_d;
      endcase
      job.nchar = k + 3'd1;
      job.nres  = 3'd4;
    end else begin
      hold_d = {hold_q[17:0], (is_pad ? 6'd0 : sx[5:0])};
      if (is_pad && pad_q != 2'd3) begin
        pad_d = pad_q + 2'd1;
      end
      done = in_item_i.in_last || (k == 3'd4);
      unique case (k)
        3'd1:    job.group = {hold_d[5:0], 18'h00000};
        3'd2:    job.group = {hold_d[11:0], 12'h000};
        3'd3:    job.group = {hold_d[17:0], 6'h00};
        default: job.group = hold_d;
      endcase
      pads      = {1'b0, pad_d} + (3'd4 - k);
      job.nres  = (pads >= 3'd3) ? 3'd0 : 3'd3 - pads;
      job.nchar = 3'd0;
    end
    cnt_d = k[1:0];
  end

  assign job_o      = job;
  assign job_push_o = accept_i && done && (job.nres != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      hold_q <= '0;
      cnt_q  <= '0;
      pad_q  <= '0;
    end else if (cfg_we_i) begin
      dir_q  <= cfg_wdata_i;
      hold_q <= '0;
      cnt_q  <= '0;
      pad_q  <= '0;
    end else if (accept_i) begin
      if (done) begin
        hold_q <= '0;
        cnt_q  <= '0;
        pad_q  <= '0;
      end else begin
        hold_q <= hold_d;
        cnt_q  <= cnt_d;
        pad_q  <= pad_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/b64_jobq.sv */
`default_nettype none

module b64_jobq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire b64_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output b64_pkg::job_t      job_o
);

  localparam int unsigned PtrW = b64_pkg::JobPtrW;

  b64_pkg::job_t       mem_q [b64_pkg::JobDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(b64_pkg::JobDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (PtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job pushed into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("job popped from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(b64_pkg::JobDepth))
    else $error("job queue count overflow");

endmodule

`default_nettype wire

/* rtl/core/b64_back.sv */
`default_nettype none

module b64_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire b64_pkg::job_t q_job_i,
  output logic               q_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output b64_pkg::out_item_t out_item_o
);

  logic               out_valid_q;
  b64_pkg::out_item_t out_q, out_d;
  logic [1:0]         idx_q;
  logic               emit;
  logic               job_done;
  logic [5:0]         sext;

  always_comb begin
    emit     = !q_empty_i && (!out_valid_q || pop);
    job_done = emit && ({1'b0, idx_q} == q_job_i.nres - 3'd1);
    unique case (idx_q)
      2'd0:    sext = q_job_i.group[23:18];
      2'd1:    sext = q_job_i.group[17:12];
      2'd2:    sext = q_job_i.group[11:6];
      default: sext = q_job_i.group[5:0];
    endcase
    if (!q_job_i.mode) begin
      out_d.out_byte = ({1'b0, idx_q} < q_job_i.nchar) ?
                       b64_pkg::sextet_to_char(sext) : b64_pkg::PadChar;
    end else begin
      unique case (idx_q)
        2'd0:    out_d.out_byte = q_job_i.group[23:16];
        2'd1:    out_d.out_byte = q_job_i.group[15:8];
        default: out_d.out_byte = q_job_i.group[7:0];
      endcase
    end
    out_d.out_last = q_job_i.last && ({1'b0, idx_q} == q_job_i.nres - 3'd1);
  end

  assign q_pop_o    = job_done;
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (job_done) begin
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> (q_job_i.nres != 3'd0))
    else $error("job without results in queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> ({1'b0, idx_q} < q_job_i.nres))
    else $error("result index past end of job");

endmodule

`default_nettype wire
